### hw/rtl/i2crw_pkg.sv
// ----------------------------------------------------------------------------
// i2crw_pkg
// Shared constants, item codes and helpers for the I2C target register window.
// ----------------------------------------------------------------------------
package i2crw_pkg;

  localparam int MAP_BYTES  = 128;
  localparam int CHIP_SLOTS = 8;

  localparam int MAP_AW = $clog2(MAP_BYTES);
  localparam int SLOT_W = (CHIP_SLOTS > 1) ? $clog2(CHIP_SLOTS) : 1;

  localparam logic [8:0] MAP_LIMIT  = 9'(MAP_BYTES);
  localparam logic [3:0] SLOT_LIMIT = 4'(CHIP_SLOTS);

  localparam logic [2:0] MODE_MATCH       = 3'd0;
  localparam logic [2:0] MODE_WRITE       = 3'd1;
  localparam logic [2:0] MODE_READ        = 3'd2;
  localparam logic [2:0] MODE_LOAD_MIRROR = 3'd3;
  localparam logic [2:0] MODE_LOAD_CHIP   = 3'd4;
  localparam logic [2:0] MODE_LOAD_BOARD  = 3'd5;

  localparam logic [7:0] FILL_BYTE = 8'hff;

  // bus address offset folded onto the populated slots
  function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] addr);
    logic [3:0] v;
    v = {1'b0, addr};
    for (int i = 0; i < 8; i++) begin
      if (v >= SLOT_LIMIT) begin
        v = v - SLOT_LIMIT;
      end
    end
    return v[SLOT_W-1:0];
  endfunction

endpackage

### hw/rtl/i2crw_ram.sv
// ----------------------------------------------------------------------------
// i2crw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2crw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/i2c_target_register_window_unit.sv
// ----------------------------------------------------------------------------
// i2c_target_register_window_unit
// A read item passes the input register, read stage and output register before
// out_valid strobes. Throughput: one item per cycle; busy never rises, mirror RAM
// read port sets the extra stage. Receiver cannot stall; results are not held.
// Reset (rst_n, sync, active low) clears pointer, slot, temps and mirror valid
// bits; chip_enabled resets to 0.
// ----------------------------------------------------------------------------
module i2c_target_register_window_unit
  import i2crw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_mode,
  input  logic [2:0] in_slave_address,
  input  logic       in_is_write,
  input  logic [7:0] in_data_byte,
  input  logic [6:0] in_store_index,
  input  logic [2:0] in_chip_slot,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       out_valid,
  output logic [7:0] out_read_data
);

  // input register
  logic       s1_vld_r;
  logic [2:0] s1_mode_r;
  logic [2:0] s1_addr_r;
  logic       s1_wr_r;
  logic [7:0] s1_data_r;
  logic [6:0] s1_sidx_r;
  logic [2:0] s1_slot_r;

  // state
  logic              chip_en_r;
  logic [7:0]        ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic [7:0]        ctemp_r [CHIP_SLOTS];
  logic [7:0]        btemp_r [CHIP_SLOTS];
  logic [MAP_BYTES-1:0] mvalid_r;

  // read stage
  logic       s2_vld_r, s2_vld_nxt;
  logic       s2_ram_r, s2_ram_nxt;
  logic       s2_hit_r, s2_hit_nxt;
  logic [7:0] s2_byte_r, s2_byte_nxt;

  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic              ram_we;
  logic              ctemp_we, btemp_we;
  logic [8:0]        sidx_ext;
  logic [MAP_AW-1:0] ram_waddr;
  logic [MAP_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [SLOT_W-1:0] load_slot;

  assign busy      = 1'b0;
  assign sidx_ext  = {2'b00, s1_sidx_r};
  assign ram_waddr = sidx_ext[MAP_AW-1:0];
  assign ram_raddr = ptr_r[MAP_AW-1:0];
  assign load_slot = s1_slot_r[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    if (start && !busy) begin
      s1_mode_r <= in_mode;
      s1_addr_r <= in_slave_address;
      s1_wr_r   <= in_is_write;
      s1_data_r <= in_data_byte;
      s1_sidx_r <= in_store_index;
      s1_slot_r <= in_chip_slot;
    end
  end

  always_comb begin
    ptr_nxt     = ptr_r;
    pend_nxt    = pend_r;
    sel_nxt     = sel_r;
    ram_we      = 1'b0;
    ctemp_we    = 1'b0;
    btemp_we    = 1'b0;
    s2_vld_nxt  = 1'b0;
    s2_ram_nxt  = 1'b0;
    s2_hit_nxt  = 1'b0;
    s2_byte_nxt = FILL_BYTE;
    if (s1_vld_r) begin
      unique case (s1_mode_r)
        MODE_MATCH: begin
          sel_nxt = slot_of(s1_addr_r);
          if (s1_wr_r) begin
            pend_nxt = 1'b1;
          end
        end
        MODE_WRITE: begin
          if (pend_r) begin
            ptr_nxt  = s1_data_r;
            pend_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + 8'd1;
          end
        end
        MODE_READ: begin
          s2_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + 8'd1;
          priority if (!chip_en_r) begin
            s2_byte_nxt = ptr_r;
          end else if (ptr_r == 8'd0) begin
            s2_byte_nxt = ctemp_r[sel_r];
          end else if (ptr_r == 8'd1) begin
            s2_byte_nxt = btemp_r[sel_r];
          end else if ({1'b0, ptr_r} < MAP_LIMIT) begin
            s2_ram_nxt = 1'b1;
            s2_hit_nxt = mvalid_r[ram_raddr];
          end else begin
            s2_byte_nxt = FILL_BYTE;
          end
        end
        MODE_LOAD_MIRROR: ram_we   = (sidx_ext < MAP_LIMIT);
        MODE_LOAD_CHIP:   ctemp_we = ({1'b0, s1_slot_r} < SLOT_LIMIT);
        MODE_LOAD_BOARD:  btemp_we = ({1'b0, s1_slot_r} < SLOT_LIMIT);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_en_r   <= 1'b0;
      ptr_r       <= 8'd0;
      pend_r      <= 1'b0;
      sel_r       <= '0;
      mvalid_r    <= '0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHIP_SLOTS; i++) begin
        ctemp_r[i] <= 8'd0;
        btemp_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        chip_en_r <= cfg_wdata;
      end
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      sel_r       <= sel_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= s2_vld_r;
      if (ram_we) begin
        mvalid_r[ram_waddr] <= 1'b1;
      end
      if (ctemp_we) begin
        ctemp_r[load_slot] <= s1_data_r;
      end
      if (btemp_we) begin
        btemp_r[load_slot] <= s1_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_ram_r  <= s2_ram_nxt;
    s2_hit_r  <= s2_hit_nxt;
    s2_byte_r <= s2_byte_nxt;
    if (s2_ram_r) begin
      out_data_r <= s2_hit_r ? ram_rdata : 8'd0;
    end else begin
      out_data_r <= s2_byte_r;
    end
  end

  i2crw_ram #(
    .WIDTH(8),
    .DEPTH(MAP_BYTES)
  ) u_mirror (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(s1_data_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

`ifndef SYNTH
  a_read_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_mode_r == MODE_READ) |-> ##2 out_valid_r)
    else $error("read item did not produce a result");

  a_strobe_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s1_vld_r && s1_mode_r == MODE_READ, 2))
    else $error("result without a read item");

  a_read_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_mode_r == MODE_READ) |=> (ptr_r == 8'($past(ptr_r) + 8'd1)))
    else $error("pointer did not advance on read");

  a_load_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_mode_r == MODE_WRITE && pend_r) |=> (!pend_r && ptr_r == $past(s1_data_r)))
    else $error("pointer load failed");
`endif

endmodule

### bench/tb_i2c_target_register_window_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_i2c_target_register_window_unit
// Self-checking bench for the I2C target register window. Drives address
// match, bus write, bus read and store load items with random start gaps.
// A scoreboard tracks pointer, slot and stores, predicts every read byte and
// compares it with the strobed result in arrival order.
// ---------------------------------------------------------------------------
module tb_i2c_target_register_window_unit
  import i2crw_pkg::*;
;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] addr;
    logic       wr;
    logic [7:0] data;
    logic [6:0] sidx;
    logic [2:0] slot;
  } bus_item_t;

  class window_scoreboard;
    bit       enabled;
    bit [7:0] pointer;
    bit       load_armed;
    bit [2:0] sel;
    bit [7:0] mirror[MAP_BYTES];
    bit [7:0] chip_temp[CHIP_SLOTS];
    bit [7:0] pcb_temp[CHIP_SLOTS];
    bit [7:0] read_bytes[$];
    int       errors;

    function new();
      enabled    = 1'b0;
      pointer    = 8'd0;
      load_armed = 1'b0;
      sel        = 3'd0;
      errors     = 0;
      foreach (mirror[i]) mirror[i] = 8'd0;
      foreach (chip_temp[i]) chip_temp[i] = 8'd0;
      foreach (pcb_temp[i]) pcb_temp[i] = 8'd0;
    endfunction

    function void set_enable(bit v);
      enabled = v;
    endfunction

    function int outstanding();
      return read_bytes.size();
    endfunction

    function void note_item(bus_item_t it);
      int       s;
      bit [7:0] b;
      s = int'(sel) % CHIP_SLOTS;
      case (it.mode)
        MODE_MATCH: begin
          sel = it.addr;
          if (it.wr) load_armed = 1'b1;
        end
        MODE_WRITE: begin
          if (load_armed) begin
            pointer    = it.data;
            load_armed = 1'b0;
          end else begin
            pointer = pointer + 8'd1;
          end
        end
        MODE_READ: begin
          if (!enabled) b = pointer;
          else if (pointer == 8'd0) b = chip_temp[s];
          else if (pointer == 8'd1) b = pcb_temp[s];
          else if (int'(pointer) < MAP_BYTES) b = mirror[pointer[6:0]];
          else b = 8'hff;
          read_bytes.push_back(b);
          pointer = pointer + 8'd1;
        end
        MODE_LOAD_MIRROR: if (int'(it.sidx) < MAP_BYTES) mirror[it.sidx] = it.data;
        MODE_LOAD_CHIP: if (int'(it.slot) < CHIP_SLOTS) chip_temp[it.slot] = it.data;
        MODE_LOAD_BOARD: if (int'(it.slot) < CHIP_SLOTS) pcb_temp[it.slot] = it.data;
        default: ;
      endcase
    endfunction

    function void check_read(logic [7:0] actual);
      bit [7:0] exp_b;
      if (read_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected read byte: expected none, actual %02h", $time, actual);
      end else begin
        exp_b = read_bytes.pop_front();
        if (actual !== exp_b) begin
          errors++;
          $display("%0t: read_data mismatch: expected %02h, actual %02h",
                   $time, exp_b, actual);
        end
      end
    endfunction

    function void flush();
      bit [7:0] exp_b;
      while (read_bytes.size() != 0) begin
        exp_b = read_bytes.pop_front();
        errors++;
        $display("%0t: missing read byte: expected %02h, actual none", $time, exp_b);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_mode = '0;
  logic [2:0] in_slave_address = '0;
  logic       in_is_write = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic [6:0] in_store_index = '0;
  logic [2:0] in_chip_slot = '0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       out_valid;
  logic [7:0] out_read_data;

  window_scoreboard sb = new();
  int sent = 0;
  bit no_gaps = 1'b0;

  i2c_target_register_window_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_slave_address(in_slave_address),
    .in_is_write     (in_is_write),
    .in_data_byte    (in_data_byte),
    .in_store_index  (in_store_index),
    .in_chip_slot    (in_chip_slot),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_read(out_read_data);
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 15);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_pointer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'($urandom_range(0, 3));
    else if (r < 45) return 8'($urandom_range(124, 131));
    else if (r < 55) return 8'($urandom_range(252, 255));
    else return 8'($urandom);
  endfunction

  function automatic bus_item_t rand_item();
    bus_item_t   it;
    logic [31:0] raw;
    raw = $urandom;
    it = raw[$bits(bus_item_t)-1:0];
    return it;
  endfunction

  function automatic bus_item_t mk(logic [2:0] mode, logic [2:0] addr, logic wr,
                                   logic [7:0] data, logic [6:0] sidx, logic [2:0] slot);
    bus_item_t it;
    it.mode = mode;
    it.addr = addr;
    it.wr   = wr;
    it.data = data;
    it.sidx = sidx;
    it.slot = slot;
    return it;
  endfunction

  // called in step with the clock; returns as soon as the item has been accepted
  task automatic send_item(input bus_item_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_mode          <= it.mode;
    in_slave_address <= it.addr;
    in_is_write      <= it.wr;
    in_data_byte     <= it.data;
    in_store_index   <= it.sidx;
    in_chip_slot     <= it.slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    if (it.mode <= MODE_LOAD_BOARD) sent++;
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (sb.outstanding() != 0 && n < 200) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enable_reg(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_enable(v);
  endtask

  task automatic bus_write_txn();
    bus_item_t it;
    int extra;
    it = rand_item();
    it.mode = MODE_MATCH;
    it.wr = 1'b1;
    send_item(it);
    if ($urandom_range(0, 9) == 0) begin
      it = rand_item();
      it.mode = MODE_MATCH;
      it.wr = 1'b0;
      send_item(it);
    end
    if ($urandom_range(0, 9) != 0) begin
      it = rand_item();
      it.mode = MODE_WRITE;
      it.data = pick_pointer();
      send_item(it);
    end
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (extra) begin
      it = rand_item();
      it.mode = MODE_WRITE;
      send_item(it);
    end
  endtask

  task automatic bus_read_txn();
    bus_item_t it;
    int n;
    if ($urandom_range(0, 4) != 0) begin
      it = rand_item();
      it.mode = MODE_MATCH;
      it.wr = 1'b0;
      send_item(it);
    end
    n = $urandom_range(1, 6);
    repeat (n) begin
      it = rand_item();
      it.mode = MODE_READ;
      send_item(it);
    end
  endtask

  task automatic load_txn();
    bus_item_t it;
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      it = rand_item();
      case ($urandom_range(0, 2))
        0: it.mode = MODE_LOAD_MIRROR;
        1: it.mode = MODE_LOAD_CHIP;
        default: it.mode = MODE_LOAD_BOARD;
      endcase
      send_item(it);
    end
  endtask

  task automatic run_phase(input bit en, input int count);
    int limit;
    int r;
    drain();
    write_enable_reg(en);
    limit = sent + count;
    while (sent < limit) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 38) bus_write_txn();
      else if (r < 73) bus_read_txn();
      else if (r < 90) load_txn();
      else send_item(rand_item());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pointer echo while the chip is disabled, wrap at 256, unused modes
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_MATCH, 3'd7, 1'b1, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_WRITE, 3'd0, 1'b0, 8'hff, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(3'd6, 3'd7, 1'b1, 8'hff, 7'h7f, 3'd7));
    send_item(mk(3'd7, 3'd7, 1'b1, 8'hff, 7'h7f, 3'd7));
    drain();
    write_enable_reg(1'b1);

    send_item(mk(MODE_LOAD_CHIP, 3'd0, 1'b0, 8'hff, 7'd0, 3'd7));
    send_item(mk(MODE_LOAD_CHIP, 3'd0, 1'b0, 8'h5a, 7'd0, 3'd0));
    send_item(mk(MODE_LOAD_BOARD, 3'd0, 1'b0, 8'h81, 7'd0, 3'd7));
    send_item(mk(MODE_LOAD_MIRROR, 3'd0, 1'b0, 8'hff, 7'h7f, 3'd0));
    send_item(mk(MODE_LOAD_MIRROR, 3'd0, 1'b0, 8'h3c, 7'd2, 3'd0));
    send_item(mk(MODE_LOAD_MIRROR, 3'd0, 1'b0, 8'h77, 7'd0, 3'd0));
    // read-direction match keeps the armed pointer load
    send_item(mk(MODE_MATCH, 3'd0, 1'b1, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_MATCH, 3'd7, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_WRITE, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_WRITE, 3'd0, 1'b0, 8'hff, 7'd0, 3'd0));
    // last mirror byte, then offsets past the map
    send_item(mk(MODE_MATCH, 3'd0, 1'b1, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_WRITE, 3'd0, 1'b0, 8'h7f, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));
    send_item(mk(MODE_READ, 3'd0, 1'b0, 8'h00, 7'd0, 3'd0));

    run_phase(1'b1, 190);
    run_phase(1'b0, 190);
    repeat (4) run_phase(1'($urandom_range(0, 1)), 190);

    drain();
    sb.flush();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/i2crw_pkg.sv
hw/rtl/i2crw_ram.sv
hw/rtl/i2c_target_register_window_unit.sv
bench/tb_i2c_target_register_window_unit.sv
